@@ hdl/hot_loop_trace_detector_defines.svh @@
// ----------------------------------------------------------------------------
// Hot loop trace detector assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HOT_LOOP_TRACE_DETECTOR_DEFINES_SVH
`define HOT_LOOP_TRACE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HLTD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HLTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/hltd_pkg.sv @@
// ----------------------------------------------------------------------------
// Hot loop trace detector package
// Operation and status codes, payload types and table command types.
// ----------------------------------------------------------------------------
package hltd_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [7:0] HOT_THRESHOLD_RESET = 8'd2;
   localparam logic [7:0] COUNT_MAX           = 8'hFF;
   localparam logic [7:0] COUNT_FIRST         = 8'd1;

   localparam logic [2:0] FUNC_REGISTER  = 3'd0;
   localparam logic [2:0] FUNC_QUERY_HOT = 3'd1;
   localparam logic [2:0] FUNC_BEGIN     = 3'd2;
   localparam logic [2:0] FUNC_END       = 3'd3;
   localparam logic [2:0] FUNC_CHECK_END = 3'd4;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_FULL       = 3'd1;
   localparam logic [2:0] STATUS_BEGIN_BUSY = 3'd2;
   localparam logic [2:0] STATUS_END_IDLE   = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN    = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] loop_addr;
      logic [31:0] end_addr;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] hit_count;
      logic       hot;
      logic       in_trace;
      logic       end_now;
      logic [2:0] status;
   } rsp_type;

   // Update request from the control logic to the table.
   typedef struct packed {
      logic inc;
      logic alloc;
   } tbl_cmd_type;

   // Lookup result from the table.
   typedef struct packed {
      logic        hit;
      logic        free_found;
      logic [7:0]  count;
      logic [31:0] end_addr;
   } tbl_look_type;

endpackage

@@ hdl/hot_loop_trace_detector.sv @@
// ----------------------------------------------------------------------------
// Hot loop trace detector
// Loop header table with sighting counts and trace begin/end tracking.
// ----------------------------------------------------------------------------
// A request is held in the input register and its response is registered in
// the result register; the table lookup and update for an item take place
// between the two. Throughput: one transaction per cycle while the response
// port is not stalled.
// Reset: synchronous, active high; clears all entry valid bits, the tracing
// flag and both pipeline valids, and returns the hot threshold to two.
module hot_loop_trace_detector #(
   parameter int ENTRIES = hltd_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hltd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hltd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   // Input register. It holds one request transaction until the result
   // register can take its response.
   logic              in_valid_ff;
   hltd_pkg::req_type in_data_ff;

   // Result register.
   logic              out_valid_ff;
   hltd_pkg::rsp_type out_data_ff;
   hltd_pkg::rsp_type out_data_in;

   // Architectural state outside the table. The end address of the active
   // loop is copied when a trace begins; entries are never freed or
   // rewritten, so the copy always equals the table's own value.
   logic        tracing_ff;
   logic        tracing_in;
   logic [31:0] active_end_ff;
   logic        load_active;
   logic [7:0]  threshold_ff;

   hltd_pkg::tbl_cmd_type  cmd;
   hltd_pkg::tbl_look_type look;

   logic       advance;
   logic       fire;
   logic [7:0] count_now;

   // The result register frees up when it is empty or being drained; the
   // request in the input register then moves on in the same edge.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   hltd_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .loop_addr (in_data_ff.loop_addr),
      .end_addr  (in_data_ff.end_addr),
      .cmd       (cmd),
      .look      (look)
   );

   // Operation decode. Every table and state write is qualified by fire so
   // a held request has no side effect until its response is registered.
   always_comb begin
      cmd.inc     = 1'b0;
      cmd.alloc   = 1'b0;
      tracing_in  = tracing_ff;
      load_active = 1'b0;
      out_data_in = '0;
      count_now   = look.count;

      case (in_data_ff.func)
         hltd_pkg::FUNC_REGISTER: begin
            if (look.hit) begin
               cmd.inc = fire;
               // The reported count is the one after the saturating step.
               if (look.count != hltd_pkg::COUNT_MAX) begin
                  count_now = look.count + 8'd1;
               end
               out_data_in.hit       = 1'b1;
               out_data_in.hit_count = count_now;
               out_data_in.hot       = (count_now >= threshold_ff);
            end else if (look.free_found) begin
               cmd.alloc = fire;
            end else begin
               out_data_in.status = hltd_pkg::STATUS_FULL;
            end
         end
         hltd_pkg::FUNC_QUERY_HOT: begin
            out_data_in.hit       = look.hit;
            out_data_in.hit_count = look.hit ? look.count : 8'd0;
            out_data_in.hot       = look.hit && (look.count >= threshold_ff);
         end
         hltd_pkg::FUNC_BEGIN: begin
            out_data_in.hit       = look.hit;
            out_data_in.hit_count = look.hit ? look.count : 8'd0;
            out_data_in.hot       = look.hit && (look.count >= threshold_ff);
            if (tracing_ff) begin
               out_data_in.status = hltd_pkg::STATUS_BEGIN_BUSY;
            end else if (!look.hit) begin
               out_data_in.status = hltd_pkg::STATUS_UNKNOWN;
            end else begin
               tracing_in  = 1'b1;
               load_active = 1'b1;
            end
         end
         hltd_pkg::FUNC_END: begin
            if (tracing_ff) begin
               tracing_in = 1'b0;
            end else begin
               out_data_in.status = hltd_pkg::STATUS_END_IDLE;
            end
         end
         hltd_pkg::FUNC_CHECK_END: begin
            out_data_in.end_now = tracing_ff && (active_end_ff <= in_data_ff.end_addr);
         end
         default: begin
            // Unused operation codes change nothing and report zeros apart from the trace flag.
         end
      endcase

      out_data_in.in_trace = tracing_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tracing_ff   <= 1'b0;
         threshold_ff <= hltd_pkg::HOT_THRESHOLD_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            tracing_ff <= tracing_in;
         end
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
      if (fire && load_active) begin
         active_end_ff <= look.end_addr;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ hdl/hltd_table.sv @@
// ----------------------------------------------------------------------------
// Hot loop trace detector table
// Associative store of loop headers with parallel match and free search.
// ----------------------------------------------------------------------------
module hltd_table #(
   parameter int ENTRIES = hltd_pkg::ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          loop_addr,
   input  logic [31:0]          end_addr,
   input  hltd_pkg::tbl_cmd_type cmd,
   output hltd_pkg::tbl_look_type look
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [ENTRIES-1:0] valid_ff;
   logic [31:0]        header_ff [ENTRIES];
   logic [31:0]        end_ff    [ENTRIES];
   logic [7:0]         count_ff  [ENTRIES];

   logic [IW-1:0] hit_idx;
   logic [IW-1:0] free_idx;
   logic          hit;
   logic          free_found;

   // Lowest matching and lowest free entries win.
   always_comb begin
      hit        = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (header_ff[i] == loop_addr)) begin
            hit     = 1'b1;
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   always_comb begin
      look.hit        = hit;
      look.free_found = free_found;
      look.count      = count_ff[hit_idx];
      look.end_addr   = end_ff[hit_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.alloc) begin
         valid_ff[free_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         header_ff[free_idx] <= loop_addr;
         end_ff[free_idx]    <= end_addr;
         count_ff[free_idx]  <= hltd_pkg::COUNT_FIRST;
      end else if (cmd.inc && (count_ff[hit_idx] != hltd_pkg::COUNT_MAX)) begin
         count_ff[hit_idx] <= count_ff[hit_idx] + 8'd1;
      end
   end

endmodule

@@ hdl/hltd_checker.sv @@
// ----------------------------------------------------------------------------
// Hot loop trace detector port checker
// Concurrent assertions on the response port, bound to the top level.
// ----------------------------------------------------------------------------
`include "hot_loop_trace_detector_defines.svh"

module hltd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hltd_pkg::rsp_type rsp_data
);

   `HLTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "response changed while stalled")

   `HLTD_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, (rsp_data.hit_count == 8'd0) && !rsp_data.hot, "lookup fields set without a hit")

   `HLTD_ASSERT_SAME(a_end_needs_trace, clock, reset, rsp_valid && rsp_data.end_now, rsp_data.in_trace, "end reported while not tracing")

   `HLTD_ASSERT_SAME(a_busy_tracing, clock, reset, rsp_valid && (rsp_data.status == hltd_pkg::STATUS_BEGIN_BUSY), rsp_data.in_trace, "begin refused while idle")

endmodule

bind hot_loop_trace_detector hltd_checker u_checker (.*);

@@ test/hot_loop_trace_detector_test.sv @@
// ----------------------------------------------------------------------------
// Hot loop trace detector testbench
// Sends loop header events through the request channel and compares every
// response with a cycle-free model of the loop table, the sighting counts and
// the trace flag. A directed pass covers the edge cases. Interpreter-like
// random traffic then runs under three back-pressure regimes, with the hot
// threshold changed between phases.
// ----------------------------------------------------------------------------
module hot_loop_trace_detector_test;

   localparam int          LOOP_SLOTS     = hltd_pkg::ENTRIES_DEFAULT;
   localparam int          POOL_SIZE      = 24;
   localparam int unsigned QUIET_LIMIT    = 2000;
   localparam logic [2:0]  FUNC_SPARE_LO  = 3'd5;
   localparam logic [2:0]  FUNC_SPARE_HI  = 3'd7;
   localparam logic [31:0] ADDR_ZERO      = 32'h0000_0000;
   localparam logic [31:0] ADDR_ONES      = 32'hFFFF_FFFF;
   localparam logic [31:0] ADDR_MID       = 32'h8000_0000;

   // Every block input has a known value from time zero.
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   hltd_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   hltd_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_data  = '0;

   // Back-pressure settings for the current phase, in per cent of cycles.
   int unsigned sender_idle_pct    = 35;
   int unsigned receiver_stall_pct = 69;

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;

   // Model of the loop table, the trace state and the threshold register.
   logic        loop_valid  [LOOP_SLOTS];
   logic [31:0] loop_header [LOOP_SLOTS];
   logic [31:0] loop_end    [LOOP_SLOTS];
   logic [7:0]  loop_count  [LOOP_SLOTS];
   logic        trace_on    = 1'b0;
   int          trace_slot  = 0;
   logic [7:0]  hot_level   = hltd_pkg::HOT_THRESHOLD_RESET;

   // Responses predicted for accepted requests, oldest first.
   hltd_pkg::rsp_type awaited_loop_rsp[$];

   // Loop addresses that the random traffic keeps returning to.
   logic [31:0] pool_header [POOL_SIZE];
   logic [31:0] pool_end    [POOL_SIZE];

   hot_loop_trace_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Loop table model
   // ---------------------------------------------------------------------

   // The lowest valid slot holding this header, or -1 when there is none.
   function automatic int loop_slot_of(input logic [31:0] addr);
      int slot;
      slot = -1;
      for (int i = LOOP_SLOTS - 1; i >= 0; i--) begin
         if (loop_valid[i] && loop_header[i] == addr) slot = i;
      end
      return slot;
   endfunction

   function automatic int lowest_free_slot();
      int slot;
      slot = -1;
      for (int i = LOOP_SLOTS - 1; i >= 0; i--) begin
         if (!loop_valid[i]) slot = i;
      end
      return slot;
   endfunction

   // Applies one accepted request to the model and returns the response that
   // the block must give for it. Only valid slots are ever read.
   function automatic hltd_pkg::rsp_type predict_loop_rsp(input hltd_pkg::req_type item);
      hltd_pkg::rsp_type outcome;
      int                slot;
      int                spare;
      outcome = '0;
      slot    = -1;
      if (item.func == hltd_pkg::FUNC_REGISTER || item.func == hltd_pkg::FUNC_QUERY_HOT ||
          item.func == hltd_pkg::FUNC_BEGIN) begin
         slot = loop_slot_of(item.loop_addr);
         if (item.func == hltd_pkg::FUNC_REGISTER) begin
            if (slot >= 0) begin
               if (loop_count[slot] != hltd_pkg::COUNT_MAX) loop_count[slot]++;
            end else begin
               spare = lowest_free_slot();
               if (spare >= 0) begin
                  // A fresh allocation is not reported as a hit.
                  loop_valid[spare]  = 1'b1;
                  loop_header[spare] = item.loop_addr;
                  loop_end[spare]    = item.end_addr;
                  loop_count[spare]  = hltd_pkg::COUNT_FIRST;
               end else begin
                  outcome.status = hltd_pkg::STATUS_FULL;
               end
            end
         end else if (item.func == hltd_pkg::FUNC_BEGIN) begin
            if (trace_on) begin
               outcome.status = hltd_pkg::STATUS_BEGIN_BUSY;
            end else if (slot < 0) begin
               outcome.status = hltd_pkg::STATUS_UNKNOWN;
            end else begin
               trace_on   = 1'b1;
               trace_slot = slot;
            end
         end
         if (slot >= 0) begin
            outcome.hit       = 1'b1;
            outcome.hit_count = loop_count[slot];
            outcome.hot       = (loop_count[slot] >= hot_level);
         end
      end else if (item.func == hltd_pkg::FUNC_END) begin
         if (trace_on) begin
            trace_on   = 1'b0;
            trace_slot = 0;
         end else begin
            outcome.status = hltd_pkg::STATUS_END_IDLE;
         end
      end else if (item.func == hltd_pkg::FUNC_CHECK_END) begin
         // The active slot is always valid while a trace runs.
         outcome.end_now = trace_on && (loop_end[trace_slot] <= item.end_addr);
      end
      outcome.in_trace = trace_on;
      return outcome;
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers and the response checker
   // ---------------------------------------------------------------------

   function automatic hltd_pkg::req_type loop_event(input logic [2:0] func,
                                                    input logic [31:0] loop_addr,
                                                    input logic [31:0] end_addr);
      hltd_pkg::req_type item;
      item.func      = func;
      item.loop_addr = loop_addr;
      item.end_addr  = end_addr;
      return item;
   endfunction

   // Offers one request, after a random number of idle cycles, and records its
   // expected response at the edge where the transaction takes place. Valid is
   // left high afterwards, so that back-to-back requests never lower and raise
   // it within one time step.
   task automatic send_loop_event(input hltd_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_loop_rsp.push_back(predict_loop_rsp(item));
   endtask

   // Stops offering requests and waits until every response has come back,
   // so that the block is idle and the threshold may be changed.
   task automatic drain_loop_events();
      req_valid <= 1'b0;
      while (awaited_loop_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_hot_threshold(input logic [7:0] level);
      csr_valid <= 1'b1;
      csr_data  <= level;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      hot_level = level;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Every response transaction is matched against the oldest prediction.
   always @(posedge clock) begin
      hltd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_loop_rsp.size() == 0) begin
            $error("response with none outstanding: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = awaited_loop_rsp.pop_front();
            check_field("hit",       32'(want.hit),       32'(rsp_data.hit));
            check_field("hit_count", 32'(want.hit_count), 32'(rsp_data.hit_count));
            check_field("hot",       32'(want.hot),       32'(rsp_data.hot));
            check_field("in_trace",  32'(want.in_trace),  32'(rsp_data.in_trace));
            check_field("end_now",   32'(want.end_now),   32'(rsp_data.end_now));
            check_field("status",    32'(want.status),    32'(rsp_data.status));
         end
      end
   end

   // The run is abandoned when no transaction of any kind has taken place for
   // a long stretch of cycles.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Fresh from reset with the default threshold of two: the idle error
   // cases, allocation, hits at both address extremes, a begin while busy,
   // the end comparison on either side of the stored end, and the unused
   // operation codes.
   task automatic test_directed_cases();
      send_loop_event(loop_event(hltd_pkg::FUNC_CHECK_END, ADDR_ZERO, ADDR_ONES));
      send_loop_event(loop_event(hltd_pkg::FUNC_END, ADDR_ZERO, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_BEGIN, ADDR_ZERO, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, ADDR_ZERO, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, ADDR_ZERO, ADDR_MID));
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, ADDR_ZERO, ADDR_ONES));
      send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, ADDR_ZERO, ADDR_ONES));
      send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, ADDR_ONES, ADDR_ONES));
      // A loop seen only once may still be traced.
      send_loop_event(loop_event(hltd_pkg::FUNC_BEGIN, ADDR_ONES, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_BEGIN, ADDR_ZERO, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_CHECK_END, ADDR_ZERO, ADDR_ONES - 1));
      send_loop_event(loop_event(hltd_pkg::FUNC_CHECK_END, ADDR_ZERO, ADDR_ONES));
      send_loop_event(loop_event(hltd_pkg::FUNC_END, ADDR_ONES, ADDR_ONES));
      send_loop_event(loop_event(hltd_pkg::FUNC_BEGIN, ADDR_ZERO, ADDR_ONES));
      send_loop_event(loop_event(hltd_pkg::FUNC_CHECK_END, ADDR_ONES, ADDR_MID - 1));
      send_loop_event(loop_event(hltd_pkg::FUNC_CHECK_END, ADDR_ONES, ADDR_MID));
      send_loop_event(loop_event(hltd_pkg::FUNC_CHECK_END, ADDR_ONES, ADDR_ZERO));
      send_loop_event(loop_event(FUNC_SPARE_LO, ADDR_ONES, ADDR_ONES));
      send_loop_event(loop_event(FUNC_SPARE_LO + 3'd1, ADDR_ZERO, ADDR_ONES));
      send_loop_event(loop_event(FUNC_SPARE_HI, ADDR_ONES, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_END, ADDR_ZERO, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_END, ADDR_ZERO, ADDR_ZERO));
      send_loop_event(loop_event(FUNC_SPARE_HI, ADDR_ONES, ADDR_ONES));
   endtask

   // A threshold of zero makes every hit hot, the maximum makes nothing below
   // a saturated count hot, and one makes any stored loop hot.
   task automatic test_threshold_extremes();
      drain_loop_events();
      write_hot_threshold(8'd0);
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, ADDR_ONES, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, ADDR_ZERO, ADDR_ZERO));
      drain_loop_events();
      write_hot_threshold(8'hFF);
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, ADDR_ZERO, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, ADDR_ONES, ADDR_ZERO));
      drain_loop_events();
      write_hot_threshold(8'd1);
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, ADDR_ONES, ADDR_ZERO));
      send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, ADDR_ZERO, ADDR_ONES));
   endtask

   // Drives one stored loop past the top of its count, with the threshold at
   // the maximum so that it turns hot only on saturation.
   task automatic test_count_saturation();
      logic [31:0] addr;
      drain_loop_events();
      write_hot_threshold(hltd_pkg::COUNT_MAX);
      addr = loop_header[0];
      repeat (int'(hltd_pkg::COUNT_MAX) + 2) begin
         send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, addr, $urandom));
      end
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, addr, $urandom));
   endtask

   // Traffic shaped like an interpreter: a loop header is sighted a few
   // times, queried, a trace is begun on it, the end address is probed around
   // the stored end and the trace ends. A share of the items is noise with
   // any operation code, and some traces are left open so that the next begin
   // finds the block busy.
   task automatic test_interpreter_traffic(input int unsigned item_budget,
                                           input logic [7:0] level);
      int unsigned sent;
      int unsigned pick;
      int unsigned sightings;
      int unsigned probes;
      logic [31:0] addr;
      logic [31:0] probe;
      sent = 0;
      drain_loop_events();
      write_hot_threshold(level);
      while (sent < item_budget) begin
         if ($urandom_range(99) < 20) begin
            send_loop_event(loop_event(3'($urandom_range(FUNC_SPARE_HI)), $urandom, $urandom));
            sent++;
         end else begin
            // Half of the episodes revisit a handful of favourite loops so
            // that their counts climb high.
            pick = ($urandom_range(1) == 1) ? $urandom_range(3) : $urandom_range(POOL_SIZE - 1);
            addr = pool_header[pick];
            sightings = $urandom_range(1, 12);
            repeat (sightings) begin
               send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, addr,
                                          ($urandom_range(9) == 0) ? $urandom : pool_end[pick]));
            end
            send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, addr, $urandom));
            send_loop_event(loop_event(hltd_pkg::FUNC_BEGIN,
                                       ($urandom_range(9) == 0) ? $urandom : addr, $urandom));
            probes = $urandom_range(0, 4);
            repeat (probes) begin
               probe = trace_on ? loop_end[trace_slot] : $urandom;
               case ($urandom_range(3))
                  0: probe = probe - 1;
                  1: probe = probe + 1;
                  2: probe = $urandom;
                  default: ;
               endcase
               send_loop_event(loop_event(hltd_pkg::FUNC_CHECK_END, $urandom, probe));
            end
            sent += sightings + probes + 2;
            if ($urandom_range(9) != 0) begin
               send_loop_event(loop_event(hltd_pkg::FUNC_END, $urandom, $urandom));
               sent++;
            end
         end
      end
   endtask

   // Fills every remaining slot with new headers, then offers more new
   // headers, which must be dropped, and a sighting of a stored loop, which
   // must still count.
   task automatic test_table_full();
      logic [31:0] addr;
      int unsigned extra;
      extra = 0;
      while (extra < 4) begin
         addr = $urandom;
         if (loop_slot_of(addr) < 0) begin
            if (lowest_free_slot() < 0) extra++;
            send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, addr, $urandom));
         end
      end
      addr = loop_header[LOOP_SLOTS - 1];
      send_loop_event(loop_event(hltd_pkg::FUNC_REGISTER, addr, $urandom));
      send_loop_event(loop_event(hltd_pkg::FUNC_QUERY_HOT, addr, $urandom));
   endtask

   initial begin
      for (int i = 0; i < LOOP_SLOTS; i++) begin
         loop_valid[i]  = 1'b0;
         loop_header[i] = '0;
         loop_end[i]    = '0;
         loop_count[i]  = '0;
      end
      pool_header[0] = ADDR_ZERO;
      pool_end[0]    = ADDR_ONES;
      pool_header[1] = ADDR_ONES;
      pool_end[1]    = ADDR_ZERO;
      for (int i = 2; i < POOL_SIZE; i++) begin
         pool_header[i] = $urandom;
         pool_end[i]    = $urandom;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly while the receiver stalls heavily.
      test_directed_cases();
      test_threshold_extremes();
      test_interpreter_traffic(250, 8'($urandom_range(1, 4)));

      // Then the other way round.
      sender_idle_pct    = 69;
      receiver_stall_pct = 35;
      test_count_saturation();
      test_interpreter_traffic(250, 8'($urandom_range(3, 40)));

      // Finally at full rate on both channels.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_interpreter_traffic(250, 8'($urandom_range(1, 255)));
      test_table_full();

      drain_loop_events();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaited_loop_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
